>>> hdl/bti_pkg.sv
package bti_pkg;

   // sizes that the transaction fields fix
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned INDEX_W    = 6;
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned WEIGHT_W   = FRAC_BITS + 1;
   localparam int unsigned DIV_W      = WORD_W + 1;
   localparam int unsigned OPND_W     = 36;
   localparam int unsigned PROD_W     = OPND_W + WEIGHT_W + 1;
   localparam int unsigned SUM_W      = PROD_W + 1;
   localparam int unsigned RND_W      = SUM_W - FRAC_BITS;
   localparam int unsigned OUT_LIMIT  = 16;
   localparam int unsigned CSR_IDX_W  = 3;

   // default sizes
   localparam int unsigned DEF_MAX_X       = 64;
   localparam int unsigned DEF_MAX_Y       = 64;
   localparam int unsigned DEF_COORD_COUNT = 3;
   localparam int unsigned DEF_MAX_FIELD   = 16;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

   // operation codes
   localparam logic [1:0] OP_LOAD_X   = 2'd0;
   localparam logic [1:0] OP_LOAD_Y   = 2'd1;
   localparam logic [1:0] OP_LOAD_G   = 2'd2;
   localparam logic [1:0] OP_EVALUATE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_TIME = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_COMP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_COMP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COMP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_SIZE = 3'd6;

   // round to nearest, ties up, then drop the fraction
   function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v + SUM_W'(32768);
      return t[SUM_W-1:FRAC_BITS];
   endfunction

endpackage

>>> hdl/bilinear_table_interpolator_unit.sv
// bilinear table interpolator
// request channel (req_): one transaction per item; operation selects a load of an
//   x axis entry, a y axis entry or a grid entry, or the evaluation of one point
// response channel (rsp_): an evaluation returns field_size transactions, component
//   0 first; all components are zero except out_component, which carries the
//   interpolated, time-ramped and saturated value; last_comp and batch_end mark the end
// csr port: plain write port; user writes only while the block is idle, not enforced
// a load is written when its request is taken and the next request may follow at once
// an evaluation runs the two axis scans (one axis memory read a cycle), up to five
//   weight and ramp divisions through the shared 16-step divider, the four grid
//   reads through the shared multiplier, then emits one component per cycle
//   while the receiver takes them
// requests are stalled for the whole evaluation; the last component sits in the
//   output register while the next request is already taken
// a stalled response holds its value, and emission pauses until it is taken
// reset returns the csr and control registers to their defaults and empties the
//   pipeline; axis and grid memories keep no reset value and must be loaded before use
module bilinear_table_interpolator_unit #(
   parameter int unsigned MAX_X       = bti_pkg::DEF_MAX_X,
   parameter int unsigned MAX_Y       = bti_pkg::DEF_MAX_Y,
   parameter int unsigned COORD_COUNT = bti_pkg::DEF_COORD_COUNT,
   parameter int unsigned MAX_FIELD   = bti_pkg::DEF_MAX_FIELD
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transaction
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [bti_pkg::INDEX_W-1:0]       req_index_x,
   input  logic [bti_pkg::INDEX_W-1:0]       req_index_y,
   input  logic signed [31:0]                req_load_value,
   input  logic signed [31:0]                req_coord_0,
   input  logic signed [31:0]                req_coord_1,
   input  logic signed [31:0]                req_coord_2,
   input  logic [31:0]                       req_now_time,
   input  logic                              req_last_point,
   // response transaction
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_comp_value,
   output logic [3:0]                        rsp_comp_index,
   output logic                              rsp_last_comp,
   output logic                              rsp_batch_end,
   // csr write port
   input  logic                              csr_we,
   input  logic [bti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);

   localparam int unsigned XAW = $clog2(MAX_X);
   localparam int unsigned YAW = $clog2(MAX_Y);
   localparam int unsigned AW  = (XAW > YAW) ? XAW : YAW;
   localparam int unsigned NW  = AW + 1;
   localparam int unsigned GAW = $clog2(MAX_X * MAX_Y);
   localparam int unsigned FS_LIMIT = (MAX_FIELD < bti_pkg::OUT_LIMIT) ?
                                      MAX_FIELD : bti_pkg::OUT_LIMIT;
   localparam int unsigned OW = bti_pkg::OPND_W;
   localparam int unsigned WW = bti_pkg::WEIGHT_W;

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_LA   = 5'd1;   // read first axis entry
   localparam logic [4:0] S_LB   = 5'd2;   // below-range check
   localparam logic [4:0] S_LC   = 5'd3;   // above-range check
   localparam logic [4:0] S_LS   = 5'd4;   // interval scan
   localparam logic [4:0] S_LLO  = 5'd5;
   localparam logic [4:0] S_LHI  = 5'd6;
   localparam logic [4:0] S_LEND = 5'd7;
   localparam logic [4:0] S_W    = 5'd8;   // weight setup
   localparam logic [4:0] S_WD   = 5'd9;   // weight division
   localparam logic [4:0] S_M0   = 5'd10;
   localparam logic [4:0] S_M1   = 5'd11;
   localparam logic [4:0] S_M2   = 5'd12;
   localparam logic [4:0] S_M3   = 5'd13;
   localparam logic [4:0] S_M4   = 5'd14;
   localparam logic [4:0] S_M5   = 5'd15;
   localparam logic [4:0] S_M6   = 5'd16;
   localparam logic [4:0] S_M7   = 5'd17;
   localparam logic [4:0] S_M8   = 5'd18;
   localparam logic [4:0] S_M9   = 5'd19;
   localparam logic [4:0] S_M10  = 5'd20;
   localparam logic [4:0] S_EMIT = 5'd21;

   localparam logic [2:0] W_XL = 3'd0;
   localparam logic [2:0] W_XH = 3'd1;
   localparam logic [2:0] W_YL = 3'd2;
   localparam logic [2:0] W_YH = 3'd3;
   localparam logic [2:0] W_RAMP = 3'd4;

   // csr registers
   logic [6:0]  x_count_ff, x_count_in;
   logic [6:0]  y_count_ff, y_count_in;
   logic [31:0] blend_ff, blend_in;
   logic [1:0]  x_comp_ff, x_comp_in;
   logic [1:0]  y_comp_ff, y_comp_in;
   logic [3:0]  out_comp_ff, out_comp_in;
   logic [4:0]  field_size_ff, field_size_in;

   // memories
   logic signed [31:0] x_axis_mem [MAX_X];
   logic signed [31:0] y_axis_mem [MAX_Y];
   logic signed [31:0] grid_mem [MAX_X * MAX_Y];
   logic signed [31:0] x_rd_ff, y_rd_ff, grid_rd_ff;

   // control
   logic [4:0]  state_ff, state_in;
   logic        ax_ff, ax_in;
   logic [2:0]  wsel_ff, wsel_in;
   logic [4:0]  k_ff, k_in;
   logic [4:0]  fs_ff, fs_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [31:0] pt_ff, pt_in;
   logic signed [31:0] yp_ff, yp_in;
   logic signed [31:0] clamp_ff, clamp_in;
   logic [AW-1:0]      lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in;
   logic [AW-1:0]      xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic signed [31:0] xc_ff, xc_in, yc_ff, yc_in;
   logic signed [31:0] x1_ff, x1_in, x2_ff, x2_in, y1_ff, y1_in, y2_ff, y2_in;
   logic [NW-1:0]      nx_ff, nx_in, ny_ff, ny_in;
   logic [WW-1:0]      w_ff [5];
   logic [WW-1:0]      w_in [5];
   logic signed [bti_pkg::PROD_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [OW-1:0] r1_ff, r1_in, r2_ff, r2_in, val_ff, val_in;
   logic signed [31:0]   res_ff, res_in;
   logic                 lp_ff, lp_in;
   logic [31:0]          now_ff, now_in;
   logic signed [31:0]   comp_value_ff, comp_value_in;
   logic [3:0]           comp_index_ff, comp_index_in;
   logic                 last_comp_ff, last_comp_in;
   logic                 batch_end_ff, batch_end_in;

   // combinational
   logic                 req_acc;
   logic                 emit_load;
   logic signed [31:0]   t_rd;
   logic [NW-1:0]        n_cur;
   logic [AW-1:0]        ax_addr;
   logic [AW-1:0]        g_row, g_col;
   logic [GAW-1:0]       grid_raddr, grid_waddr;
   logic signed [OW-1:0] mul_a;
   logic [WW-1:0]        mul_b;
   logic signed [bti_pkg::PROD_W-1:0] mul_p;
   logic signed [bti_pkg::SUM_W-1:0]  sum;
   logic signed [bti_pkg::RND_W-1:0]  rnd_sum, rnd_prod;
   logic signed [32:0]   w_num, w_den;
   logic [32:0]          num_mag, den_mag;
   logic                 w_zero, w_one;
   logic                 div_start, div_done;
   logic [bti_pkg::FRAC_BITS-1:0] div_q;
   logic                 x_in_range, y_in_range;

   function automatic logic signed [31:0] pick(input logic [1:0] sel,
                                               input logic signed [31:0] c0,
                                               input logic signed [31:0] c1,
                                               input logic signed [31:0] c2);
      logic signed [31:0] r;
      r = c0;
      if (32'(sel) < COORD_COUNT) begin
         case (sel)
            2'd1:    r = c1;
            2'd2:    r = c2;
            default: r = c0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [NW-1:0] clamp_n(input logic [6:0] v, input int unsigned top);
      logic [NW-1:0] r;
      if (32'(v) < 32'd2)
         r = NW'(2);
      else if (32'(v) > top)
         r = NW'(top);
      else
         r = NW'(v);
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign x_in_range = (32'(req_index_x) < MAX_X);
   assign y_in_range = (32'(req_index_y) < MAX_Y);

   // read data and the entry count of the axis being searched
   assign t_rd  = ax_ff ? y_rd_ff : x_rd_ff;
   assign n_cur = ax_ff ? ny_ff : nx_ff;

   always_comb begin
      case (state_ff)
         S_LB:    ax_addr = AW'(n_cur - 1'b1);
         S_LC:    ax_addr = AW'(1);
         S_LS:    ax_addr = i_ff + 1'b1;
         S_LLO:   ax_addr = lo_ff;
         S_LHI:   ax_addr = hi_ff;
         default: ax_addr = '0;
      endcase
   end

   // grid corners: row y_hi first, then row y_lo
   always_comb begin
      case (state_ff)
         S_M0:    begin g_row = yhi_ff; g_col = xlo_ff; end
         S_M1:    begin g_row = yhi_ff; g_col = xhi_ff; end
         S_M2:    begin g_row = ylo_ff; g_col = xlo_ff; end
         S_M3:    begin g_row = ylo_ff; g_col = xhi_ff; end
         default: begin g_row = ylo_ff; g_col = xlo_ff; end
      endcase
   end

   assign grid_raddr = GAW'(32'(g_row) * MAX_X + 32'(g_col));
   assign grid_waddr = GAW'(32'(req_index_y) * MAX_X + 32'(req_index_x));

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_acc && req_operation == bti_pkg::OP_LOAD_X && x_in_range)
         x_axis_mem[XAW'(req_index_x)] <= req_load_value;
      x_rd_ff <= x_axis_mem[XAW'(ax_addr)];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_operation == bti_pkg::OP_LOAD_Y && y_in_range)
         y_axis_mem[YAW'(req_index_y)] <= req_load_value;
      y_rd_ff <= y_axis_mem[YAW'(ax_addr)];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_operation == bti_pkg::OP_LOAD_G && x_in_range && y_in_range)
         grid_mem[grid_waddr] <= req_load_value;
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   // shared multiplier, grid value or partial result times a weight
   always_comb begin
      case (state_ff)
         S_M1, S_M3: begin mul_a = OW'(grid_rd_ff); mul_b = w_ff[W_XL]; end
         S_M2, S_M4: begin mul_a = OW'(grid_rd_ff); mul_b = w_ff[W_XH]; end
         S_M6:       begin mul_a = r1_ff;  mul_b = w_ff[W_YH]; end
         S_M7:       begin mul_a = r2_ff;  mul_b = w_ff[W_YL]; end
         S_M9:       begin mul_a = val_ff; mul_b = w_ff[W_RAMP]; end
         default:    begin mul_a = val_ff; mul_b = w_ff[W_RAMP]; end
      endcase
   end

   assign mul_p    = mul_a * $signed({1'b0, mul_b});
   assign sum      = bti_pkg::SUM_W'(acc_ff) + bti_pkg::SUM_W'(prod_ff);
   assign rnd_sum  = bti_pkg::rnd_q16(sum);
   assign rnd_prod = bti_pkg::rnd_q16(bti_pkg::SUM_W'(prod_ff));

   // weight operands; axis: opposite signs or a zero give 0; a ratio of 1 or more gives 1
   always_comb begin
      case (wsel_ff)
         W_XL:    begin w_num = 33'(x2_ff) - 33'(xc_ff); w_den = 33'(x2_ff) - 33'(x1_ff); end
         W_XH:    begin w_num = 33'(xc_ff) - 33'(x1_ff); w_den = 33'(x2_ff) - 33'(x1_ff); end
         W_YL:    begin w_num = 33'(y2_ff) - 33'(yc_ff); w_den = 33'(y2_ff) - 33'(y1_ff); end
         W_YH:    begin w_num = 33'(yc_ff) - 33'(y1_ff); w_den = 33'(y2_ff) - 33'(y1_ff); end
         default: begin w_num = '0; w_den = '0; end
      endcase
      if (wsel_ff == W_RAMP) begin
         num_mag = {1'b0, now_ff};
         den_mag = {1'b0, blend_ff};
         w_zero  = 1'b0;
         w_one   = (blend_ff == '0) || (now_ff >= blend_ff);
      end else begin
         num_mag = w_num[32] ? 33'(-w_num) : 33'(w_num);
         den_mag = w_den[32] ? 33'(-w_den) : 33'(w_den);
         w_zero  = (w_den == '0) || (w_num == '0) || (w_num[32] != w_den[32]);
         w_one   = (num_mag >= den_mag);
      end
   end

   assign div_start = (state_ff == S_W) && !w_zero && !w_one;

   bti_wdiv u_wdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_mag),
      .den      (den_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // next-state and datapath
   always_comb begin
      x_count_in    = x_count_ff;
      y_count_in    = y_count_ff;
      blend_in      = blend_ff;
      x_comp_in     = x_comp_ff;
      y_comp_in     = y_comp_ff;
      out_comp_in   = out_comp_ff;
      field_size_in = field_size_ff;
      state_in      = state_ff;
      ax_in         = ax_ff;
      wsel_in       = wsel_ff;
      k_in          = k_ff;
      fs_in         = fs_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      pt_in    = pt_ff;    yp_in    = yp_ff;    clamp_in = clamp_ff;
      lo_in    = lo_ff;    hi_in    = hi_ff;    i_in     = i_ff;
      xlo_in   = xlo_ff;   xhi_in   = xhi_ff;   ylo_in   = ylo_ff;   yhi_in = yhi_ff;
      xc_in    = xc_ff;    yc_in    = yc_ff;
      x1_in    = x1_ff;    x2_in    = x2_ff;    y1_in    = y1_ff;    y2_in  = y2_ff;
      nx_in    = nx_ff;    ny_in    = ny_ff;
      for (int j = 0; j < 5; j++)
         w_in[j] = w_ff[j];
      prod_in  = prod_ff;  acc_in   = acc_ff;
      r1_in    = r1_ff;    r2_in    = r2_ff;    val_in   = val_ff;   res_in = res_ff;
      lp_in    = lp_ff;    now_in   = now_ff;
      comp_value_in = comp_value_ff;
      comp_index_in = comp_index_ff;
      last_comp_in  = last_comp_ff;
      batch_end_in  = batch_end_ff;

      if (csr_we) begin
         case (csr_index)
            bti_pkg::CSR_X_COUNT:    x_count_in    = csr_wdata[6:0];
            bti_pkg::CSR_Y_COUNT:    y_count_in    = csr_wdata[6:0];
            bti_pkg::CSR_BLEND_TIME: blend_in      = csr_wdata;
            bti_pkg::CSR_X_COMP:     x_comp_in     = csr_wdata[1:0];
            bti_pkg::CSR_Y_COMP:     y_comp_in     = csr_wdata[1:0];
            bti_pkg::CSR_OUT_COMP:   out_comp_in   = csr_wdata[3:0];
            bti_pkg::CSR_FIELD_SIZE: field_size_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_operation == bti_pkg::OP_EVALUATE) begin
               pt_in  = pick(x_comp_ff, req_coord_0, req_coord_1, req_coord_2);
               yp_in  = pick(y_comp_ff, req_coord_0, req_coord_1, req_coord_2);
               nx_in  = clamp_n(x_count_ff, MAX_X);
               ny_in  = clamp_n(y_count_ff, MAX_Y);
               fs_in  = 5'(clamp_n_fs(field_size_ff));
               lp_in  = req_last_point;
               now_in = req_now_time;
               ax_in  = 1'b0;
               state_in = S_LA;
            end
         end
         S_LA: state_in = S_LB;
         S_LB: begin
            // at or below the first entry
            if (pt_ff <= t_rd) begin
               lo_in    = '0;
               hi_in    = AW'(1);
               clamp_in = t_rd;
               state_in = S_LLO;
            end else begin
               state_in = S_LC;
            end
         end
         S_LC: begin
            // at or above the last entry in use
            if (pt_ff >= t_rd) begin
               lo_in    = AW'(n_cur - NW'(2));
               hi_in    = AW'(n_cur - 1'b1);
               clamp_in = t_rd;
               state_in = S_LLO;
            end else begin
               i_in     = AW'(1);
               state_in = S_LS;
            end
         end
         S_LS: begin
            // first entry from index 1 that is not below the coordinate
            if ((NW'(i_ff) < n_cur - 1'b1) && (t_rd < pt_ff)) begin
               i_in = i_ff + 1'b1;
            end else begin
               lo_in    = i_ff - 1'b1;
               hi_in    = i_ff;
               clamp_in = pt_ff;
               state_in = S_LLO;
            end
         end
         S_LLO: state_in = S_LHI;
         S_LHI: begin
            if (ax_ff) y1_in = t_rd;
            else       x1_in = t_rd;
            state_in = S_LEND;
         end
         S_LEND: begin
            if (!ax_ff) begin
               x2_in  = t_rd;
               xlo_in = lo_ff;
               xhi_in = hi_ff;
               xc_in  = clamp_ff;
               ax_in  = 1'b1;
               pt_in  = yp_ff;
               state_in = S_LA;
            end else begin
               y2_in  = t_rd;
               ylo_in = lo_ff;
               yhi_in = hi_ff;
               yc_in  = clamp_ff;
               wsel_in  = W_XL;
               state_in = S_W;
            end
         end
         S_W: begin
            if (w_zero || w_one) begin
               w_in[wsel_ff] = w_zero ? '0 : bti_pkg::ONE_Q16;
               if (wsel_ff == W_RAMP) begin
                  state_in = S_M0;
               end else begin
                  wsel_in = wsel_ff + 1'b1;
               end
            end else begin
               state_in = S_WD;
            end
         end
         S_WD: begin
            if (div_done) begin
               w_in[wsel_ff] = {1'b0, div_q};
               if (wsel_ff == W_RAMP) begin
                  state_in = S_M0;
               end else begin
                  wsel_in  = wsel_ff + 1'b1;
                  state_in = S_W;
               end
            end
         end
         S_M0: state_in = S_M1;
         S_M1: begin
            prod_in  = mul_p;
            state_in = S_M2;
         end
         S_M2: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = S_M3;
         end
         S_M3: begin
            r1_in    = OW'(rnd_sum);
            prod_in  = mul_p;
            state_in = S_M4;
         end
         S_M4: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = S_M5;
         end
         S_M5: begin
            r2_in    = OW'(rnd_sum);
            state_in = S_M6;
         end
         S_M6: begin
            prod_in  = mul_p;
            state_in = S_M7;
         end
         S_M7: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = S_M8;
         end
         S_M8: begin
            val_in   = OW'(rnd_sum);
            state_in = S_M9;
         end
         S_M9: begin
            prod_in  = mul_p;
            state_in = S_M10;
         end
         S_M10: begin
            // saturate the ramped value to 32 bits
            if (rnd_prod > bti_pkg::RND_W'(33'sh0_7FFF_FFFF))
               res_in = 32'sh7FFF_FFFF;
            else if (rnd_prod < -bti_pkg::RND_W'(33'sh0_8000_0000))
               res_in = 32'sh8000_0000;
            else
               res_in = 32'(rnd_prod);
            k_in     = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_load) begin
               rsp_valid_in  = 1'b1;
               comp_value_in = ({1'b0, out_comp_ff} == k_ff) ? res_ff : '0;
               comp_index_in = k_ff[3:0];
               last_comp_in  = (k_ff == fs_ff - 1'b1);
               batch_end_in  = (k_ff == fs_ff - 1'b1) && lp_ff;
               k_in          = k_ff + 1'b1;
               if (k_ff == fs_ff - 1'b1)
                  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // field size in use, between 1 and the component limit
   function automatic logic [4:0] clamp_n_fs(input logic [4:0] v);
      logic [4:0] r;
      if (v == '0)
         r = 5'd1;
      else if (32'(v) > FS_LIMIT)
         r = 5'(FS_LIMIT);
      else
         r = v;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         ax_ff         <= 1'b0;
         wsel_ff       <= W_XL;
         k_ff          <= '0;
         x_count_ff    <= 7'd2;
         y_count_ff    <= 7'd2;
         blend_ff      <= '0;
         x_comp_ff     <= 2'd0;
         y_comp_ff     <= 2'd1;
         out_comp_ff   <= 4'd0;
         field_size_ff <= 5'd1;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ax_ff         <= ax_in;
         wsel_ff       <= wsel_in;
         k_ff          <= k_in;
         x_count_ff    <= x_count_in;
         y_count_ff    <= y_count_in;
         blend_ff      <= blend_in;
         x_comp_ff     <= x_comp_in;
         y_comp_ff     <= y_comp_in;
         out_comp_ff   <= out_comp_in;
         field_size_ff <= field_size_in;
      end
      fs_ff    <= fs_in;
      pt_ff    <= pt_in;    yp_ff  <= yp_in;   clamp_ff <= clamp_in;
      lo_ff    <= lo_in;    hi_ff  <= hi_in;   i_ff     <= i_in;
      xlo_ff   <= xlo_in;   xhi_ff <= xhi_in;  ylo_ff   <= ylo_in;   yhi_ff <= yhi_in;
      xc_ff    <= xc_in;    yc_ff  <= yc_in;
      x1_ff    <= x1_in;    x2_ff  <= x2_in;   y1_ff    <= y1_in;    y2_ff  <= y2_in;
      nx_ff    <= nx_in;    ny_ff  <= ny_in;
      for (int j = 0; j < 5; j++)
         w_ff[j] <= w_in[j];
      prod_ff  <= prod_in;  acc_ff <= acc_in;
      r1_ff    <= r1_in;    r2_ff  <= r2_in;   val_ff   <= val_in;   res_ff <= res_in;
      lp_ff    <= lp_in;    now_ff <= now_in;
      comp_value_ff <= comp_value_in;
      comp_index_ff <= comp_index_in;
      last_comp_ff  <= last_comp_in;
      batch_end_ff  <= batch_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_comp_value = comp_value_ff;
   assign rsp_comp_index = comp_index_ff;
   assign rsp_last_comp  = last_comp_ff;
   assign rsp_batch_end  = batch_end_ff;

endmodule

>>> hdl/bti_wdiv.sv
module bti_wdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bti_pkg::DIV_W-1:0]        num,
   input  logic [bti_pkg::DIV_W-1:0]        den,
   output logic                             done,
   output logic [bti_pkg::FRAC_BITS-1:0]    quotient
);

   // restoring division of (num << 16) / den, one quotient bit a cycle, num < den

   localparam int unsigned CW = $clog2(bti_pkg::FRAC_BITS);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [bti_pkg::DIV_W:0]        rem_ff, rem_in;
   logic [bti_pkg::DIV_W-1:0]      den_ff, den_in;
   logic [bti_pkg::FRAC_BITS-1:0]  q_ff, q_in;
   logic [bti_pkg::DIV_W:0]        rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      rem_sh  = {rem_ff[bti_pkg::DIV_W-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[bti_pkg::FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[bti_pkg::FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(bti_pkg::FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> hdl/bti_checker.sv
module bti_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_comp_value,
   input logic [3:0]         rsp_comp_index,
   input logic               rsp_last_comp,
   input logic               rsp_batch_end
);

   // batch end only rides on the last component
   a_batch_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_batch_end || rsp_last_comp))
      else $error("batch_end without last_comp");

   // components of a point follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_comp) |=> rsp_valid)
      else $error("gap inside a point");

   // component indexes count up by one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_comp) |=>
         (rsp_comp_index == $past(rsp_comp_index) + 4'd1))
      else $error("component index out of order");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_comp_value)
                                    && $stable(rsp_comp_index)))
      else $error("stalled response changed");

endmodule

bind bilinear_table_interpolator_unit bti_checker u_bti_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_comp_value (rsp_comp_value),
   .rsp_comp_index (rsp_comp_index),
   .rsp_last_comp  (rsp_last_comp),
   .rsp_batch_end  (rsp_batch_end)
);
